// File: rtl/multichannel_pwm_shadowed_top_assert.svh
// Assertion macros used by the checker file of the PWM block.
`ifndef MULTICHANNEL_PWM_SHADOWED_TOP_ASSERT_SVH
`define MULTICHANNEL_PWM_SHADOWED_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mps_pkg.sv
package mps_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_EN   = 2'd1,
    OP_SET_DUTY = 2'd2
  } opcode_t;

  localparam int          PERCENT_FULL = 100;
  localparam logic [7:0]  PERIOD_RESET = 8'd100;
  localparam int          LEVEL_W      = 6;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 43699, and
  // period * percent never exceeds 25500.
  localparam int RECIP_MUL   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALE_W     = 20;

  typedef logic [SCALE_W-1:0] scale_tab_t [0:PERCENT_FULL];

  function automatic scale_tab_t build_scale_tab();
    scale_tab_t tab;
    for (int i = 0; i <= PERCENT_FULL; i++) begin
      tab[i] = SCALE_W'(i * RECIP_MUL);
    end
    return tab;
  endfunction

  // Percent pre-scaled by the reciprocal of 100, indexed by percent.
  localparam scale_tab_t SCALE_TAB = build_scale_tab();

endpackage

// File: rtl/multichannel_pwm_shadowed_top.sv
// Shadowed multichannel PWM. Each transfer on the in_ channel is one item:
// a tick advances the period counter, a set-enable or set-duty item writes a
// channel's shadow register, and every item returns exactly one transfer on
// the out_ channel carrying the channel levels after that item. Shadow values
// reach the live registers together at a period wrap, and only if some shadow
// was written since the last copy. The block takes one item per clock and
// holds that rate as long as results are taken; each item passes the input
// register and then the result register. The rate is set by the
// combinational state update between those two registers, where the duty
// scaling uses one 8 by 20 bit multiply against a percent table.
// cfg_we writes period_r; it is meant to be written only while idle.
module multichannel_pwm_shadowed_top #(
  parameter int CHANNELS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_channel,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_pwm_levels
);

  // Only the first six channels are visible on the level output.
  localparam int SHOWN = (CHANNELS < mps_pkg::LEVEL_W) ? CHANNELS : mps_pkg::LEVEL_W;
  localparam int PROD_W = 8 + mps_pkg::SCALE_W;

  // Period register.
  logic [7:0] period_r;

  // Input register.
  logic       stage_valid_r;
  logic [1:0] stage_opcode_r;
  logic [2:0] stage_channel_r;
  logic [7:0] stage_value_r;

  // Block state.
  logic [7:0] counter_r, counter_nxt;
  logic [7:0] live_duty_r     [CHANNELS];
  logic [7:0] live_duty_nxt   [CHANNELS];
  logic       live_en_r       [CHANNELS];
  logic       live_en_nxt     [CHANNELS];
  logic [7:0] shadow_duty_r   [CHANNELS];
  logic [7:0] shadow_duty_nxt [CHANNELS];
  logic       shadow_en_r     [CHANNELS];
  logic       shadow_en_nxt   [CHANNELS];
  logic       pending_r, pending_nxt;

  // Result register.
  logic       out_valid_r;
  logic [5:0] levels_r, levels_nxt;

  logic accept_in;
  logic advance;

  // The stage hands its item on whenever the result register is free or is
  // being emptied in this cycle, so the input stalls only behind a stalled
  // result.
  assign advance   = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = stage_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_pwm_levels = levels_r;

  // Duty scaling: period * min(value, 100) / 100, done as one multiply by a
  // percent table that already carries the reciprocal of 100.
  logic [6:0]                  pct;
  logic [mps_pkg::SCALE_W-1:0] pct_scaled;
  logic [PROD_W-1:0]           duty_prod;
  logic [7:0]                  duty_new;

  always_comb begin
    if (stage_value_r > 8'(mps_pkg::PERCENT_FULL)) begin
      pct = 7'(mps_pkg::PERCENT_FULL);
    end else begin
      pct = stage_value_r[6:0];
    end
    pct_scaled = mps_pkg::SCALE_TAB[pct];
    duty_prod  = PROD_W'(period_r) * PROD_W'(pct_scaled);
    duty_new   = 8'(duty_prod >> mps_pkg::RECIP_SHIFT);
  end

  // Next state for the item leaving the input register.
  logic [7:0] counter_inc;

  always_comb begin
    counter_inc = counter_r + 8'd1;
    counter_nxt = counter_r;
    pending_nxt = pending_r;
    for (int i = 0; i < CHANNELS; i++) begin
      live_duty_nxt[i]   = live_duty_r[i];
      live_en_nxt[i]     = live_en_r[i];
      shadow_duty_nxt[i] = shadow_duty_r[i];
      shadow_en_nxt[i]   = shadow_en_r[i];
    end

    unique case (mps_pkg::opcode_t'(stage_opcode_r))
      mps_pkg::OP_TICK: begin
        counter_nxt = counter_inc;
        // Wrap at the period; a lowered period or a period of zero wraps too.
        if (period_r <= counter_inc) begin
          counter_nxt = 8'd0;
          if (pending_r) begin
            for (int i = 0; i < CHANNELS; i++) begin
              live_duty_nxt[i] = shadow_duty_r[i];
              live_en_nxt[i]   = shadow_en_r[i];
            end
            pending_nxt = 1'b0;
          end
        end
      end
      mps_pkg::OP_SET_EN: begin
        // A channel number beyond the last channel leaves everything alone.
        for (int i = 0; i < CHANNELS; i++) begin
          if (32'(stage_channel_r) == i) begin
            shadow_en_nxt[i] = stage_value_r[0];
            pending_nxt      = 1'b1;
          end
        end
      end
      mps_pkg::OP_SET_DUTY: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (32'(stage_channel_r) == i) begin
            shadow_duty_nxt[i] = duty_new;
            pending_nxt        = 1'b1;
          end
        end
      end
      default: begin
        // The unused opcode changes nothing but still reports the levels.
      end
    endcase

    // Levels after the item, from the updated live state and counter.
    levels_nxt = '0;
    for (int i = 0; i < SHOWN; i++) begin
      levels_nxt[i] = live_en_nxt[i] && (counter_nxt <= live_duty_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= mps_pkg::PERIOD_RESET;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      counter_r     <= 8'd0;
      pending_r     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        live_duty_r[i]   <= 8'd0;
        live_en_r[i]     <= 1'b0;
        shadow_duty_r[i] <= 8'd0;
        shadow_en_r[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end

      if (accept_in) begin
        stage_valid_r <= 1'b1;
      end else if (advance) begin
        stage_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
        counter_r   <= counter_nxt;
        pending_r   <= pending_nxt;
        for (int i = 0; i < CHANNELS; i++) begin
          live_duty_r[i]   <= live_duty_nxt[i];
          live_en_r[i]     <= live_en_nxt[i];
          shadow_duty_r[i] <= shadow_duty_nxt[i];
          shadow_en_r[i]   <= shadow_en_nxt[i];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      stage_opcode_r  <= in_opcode;
      stage_channel_r <= in_channel;
      stage_value_r   <= in_value;
    end
    if (advance) begin
      levels_r <= levels_nxt;
    end
  end

endmodule

// File: rtl/mps_checker.sv
`include "multichannel_pwm_shadowed_top_assert.svh"

module mps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_pwm_levels
);

  // A stalled result stays offered and unchanged.
  `MPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pwm_levels), "stalled result changed")

  // The result drops only after a transfer.
  `MPS_ASSERT_SAME(a_out_drop, $fell(out_valid), $past(!out_stall), "result lost without transfer")

  // The input stalls only behind a stalled result.
  `MPS_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without backpressure")

  // An accepted item reaches the output in the cycle after its stage can move.
  `MPS_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 (!out_valid || !out_stall), out_valid, "accepted item did not appear")

endmodule

bind multichannel_pwm_shadowed_top mps_checker u_mps_checker (.*);

// File: test/multichannel_pwm_shadowed_top_checker.sv
module multichannel_pwm_shadowed_top_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [2:0]                  in_channel,
  input  logic [7:0]                  in_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [mps_pkg::LEVEL_W-1:0] out_pwm_levels,
  output int                          fail_count,
  output int                          open_results
);

  localparam int NCH = mps_pkg::LEVEL_W;

  // Predicted block state.
  logic [7:0]                  wrap_at;
  logic [7:0]                  phase_count;
  logic [7:0]                  duty_live [NCH];
  logic                        en_live [NCH];
  logic [7:0]                  duty_shadow [NCH];
  logic                        en_shadow [NCH];
  logic                        copy_pending;
  logic [mps_pkg::LEVEL_W-1:0] levels_q [$];

  task automatic report_fault(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one input item to the predicted state and returns the levels after it.
  task automatic advance_pwm(input logic [1:0] code, input logic [2:0] ch,
                             input logic [7:0] val,
                             output logic [mps_pkg::LEVEL_W-1:0] levels);
    mps_pkg::opcode_t op;
    int               pct;
    op = mps_pkg::opcode_t'(code);
    unique case (op)
      mps_pkg::OP_TICK: begin
        phase_count = phase_count + 8'd1;
        if (wrap_at <= phase_count) begin
          phase_count = '0;
          if (copy_pending) begin
            for (int i = 0; i < NCH; i++) begin
              duty_live[i] = duty_shadow[i];
              en_live[i]   = en_shadow[i];
            end
            copy_pending = 1'b0;
          end
        end
      end
      mps_pkg::OP_SET_EN: begin
        if (ch < NCH) begin
          en_shadow[ch] = val[0];
          copy_pending  = 1'b1;
        end
      end
      mps_pkg::OP_SET_DUTY: begin
        if (ch < NCH) begin
          pct = (val > mps_pkg::PERCENT_FULL) ? mps_pkg::PERCENT_FULL : int'(val);
          duty_shadow[ch] = 8'((int'(wrap_at) * pct) / mps_pkg::PERCENT_FULL);
          copy_pending    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NCH; i++) begin
      levels[i] = en_live[i] && (phase_count <= duty_live[i]);
    end
  endtask

  always @(posedge clk) begin
    logic [mps_pkg::LEVEL_W-1:0] want;
    if (!rst_n) begin
      wrap_at      = mps_pkg::PERIOD_RESET;
      phase_count  = '0;
      copy_pending = 1'b0;
      for (int i = 0; i < NCH; i++) begin
        duty_live[i]   = '0;
        en_live[i]     = 1'b0;
        duty_shadow[i] = '0;
        en_shadow[i]   = 1'b0;
      end
      levels_q.delete();
    end else begin
      if (cfg_we) begin
        wrap_at = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (levels_q.size() == 0) begin
          report_fault($sformatf("unexpected result, levels %b", out_pwm_levels));
        end else begin
          want = levels_q.pop_front();
          if (out_pwm_levels !== want) begin
            report_fault($sformatf("pwm_levels got %b, expected %b", out_pwm_levels, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_pwm(in_opcode, in_channel, in_value, want);
        levels_q.push_back(want);
      end
    end
    open_results <= levels_q.size();
  end

endmodule

// File: test/multichannel_pwm_shadowed_top_test.sv
// Stimulus and verdict for the shadowed PWM block. The checker instance
// beside the block watches both channels, predicts every result and counts
// failures; this module only drives items, the period register and the
// result stall, and decides the outcome at the end.
module multichannel_pwm_shadowed_top_test;

  // The opcode that the block must treat as a no-operation.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 33;
  localparam int PHASES       = 8;

  // Period setting per phase. The first phase keeps the reset period, so it
  // is not written. The long phase at 255 lets the counter climb all the way
  // to 254, and the phase after it lowers the period below the counter.
  localparam logic [7:0] PHASE_PERIOD [PHASES] = '{
    8'd100, 8'd255, 8'd5, 8'd0, 8'd1, 8'd12, 8'd255, 8'd2
  };
  localparam int PHASE_ITEMS [PHASES] = '{130, 300, 60, 40, 40, 60, 60, 40};
  localparam int PHASE_TICK_PCT [PHASES] = '{85, 92, 60, 60, 60, 65, 80, 60};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_opcode;
  logic [2:0] in_channel;
  logic [7:0] in_value;
  logic       out_valid;
  logic       out_stall;
  logic [5:0] out_pwm_levels;

  int fail_count;
  int open_results;
  int cycles = 0;
  // While set, neither side idles.
  bit calm;

  always #10 clk = ~clk;

  multichannel_pwm_shadowed_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_channel     (in_channel),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pwm_levels (out_pwm_levels)
  );

  multichannel_pwm_shadowed_top_checker i_levels_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_channel     (in_channel),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pwm_levels (out_pwm_levels),
    .fail_count     (fail_count),
    .open_results   (open_results)
  );

  // The result side stalls about a third of the time, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multichannel_pwm_shadowed_top: mismatch");
      $finish;
    end
  end

  // Offers one item and returns in the time step of its transfer. Random
  // gaps come first, so a gap never lowers valid while an item is offered.
  // The caller must either offer the next item or lower valid in that step.
  task automatic send_item(input logic [1:0] op, input logic [2:0] ch, input logic [7:0] val);
    while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_channel <= ch;
    in_value   <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // One random item. Ticks dominate so that periods wrap often and the
  // shadow copies reach the live registers; the rest are shadow writes,
  // now and then to a channel that does not exist, and a few spare opcodes.
  task automatic send_random(input int tick_pct);
    logic [1:0] op;
    logic [2:0] ch;
    logic [7:0] val;
    int         pick;
    int         span;
    pick = $urandom_range(0, 99);
    span = 100 - tick_pct;
    ch   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    val  = 8'($urandom_range(0, 255));
    if (pick < tick_pct) begin
      op = mps_pkg::OP_TICK;
      ch = 3'($urandom_range(0, 7));
    end else if (pick - tick_pct < span * 4 / 10) begin
      op = mps_pkg::OP_SET_EN;
    end else if (pick - tick_pct < span * 9 / 10) begin
      op = mps_pkg::OP_SET_DUTY;
      // Mostly real percentages, sometimes values that must saturate.
      if ($urandom_range(0, 9) < 7) begin
        val = 8'($urandom_range(0, mps_pkg::PERCENT_FULL));
      end
    end else begin
      op = OP_SPARE;
    end
    send_item(op, ch, val);
  endtask

  // Writes the period once the block has gone quiet: valid is lowered in the
  // step of the last transfer, every expected result must have arrived, and
  // a drain wait lets the pipeline settle.
  task automatic write_period(input logic [7:0] ticks);
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_opcode  <= mps_pkg::OP_TICK;
    in_channel <= '0;
    in_value   <= '0;
    calm       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset period. A tick with ignored fields at their
    // top values, then enables with bit 0 on and off and the upper bits set,
    // then duties at zero, one, half and full scale, just past full scale and at the
    // 8-bit maximum. Writes to channels 6 and 7 must be dropped without
    // arming the copy, and the spare opcode only reports the levels. The
    // closing ticks run while all shadows wait for the next wrap.
    send_item(mps_pkg::OP_TICK, 3'd7, 8'hFF);
    send_item(mps_pkg::OP_SET_EN, 3'd0, 8'h01);
    send_item(mps_pkg::OP_SET_EN, 3'd1, 8'hFF);
    send_item(mps_pkg::OP_SET_EN, 3'd2, 8'hFE);
    send_item(mps_pkg::OP_SET_EN, 3'd3, 8'h01);
    send_item(mps_pkg::OP_SET_EN, 3'd4, 8'h01);
    send_item(mps_pkg::OP_SET_EN, 3'd5, 8'h81);
    send_item(mps_pkg::OP_SET_DUTY, 3'd0, 8'd0);
    send_item(mps_pkg::OP_SET_DUTY, 3'd1, 8'd100);
    send_item(mps_pkg::OP_SET_DUTY, 3'd2, 8'd50);
    send_item(mps_pkg::OP_SET_DUTY, 3'd3, 8'd101);
    send_item(mps_pkg::OP_SET_DUTY, 3'd4, 8'd1);
    send_item(mps_pkg::OP_SET_DUTY, 3'd5, 8'd255);
    send_item(mps_pkg::OP_SET_EN, 3'd6, 8'h01);
    send_item(mps_pkg::OP_SET_DUTY, 3'd7, 8'd90);
    send_item(OP_SPARE, 3'd3, 8'hAA);
    send_item(OP_SPARE, 3'd4, 8'h55);
    send_item(mps_pkg::OP_TICK, 3'd0, 8'h00);
    send_item(mps_pkg::OP_TICK, 3'd5, 8'h0F);
    send_item(mps_pkg::OP_TICK, 3'd2, 8'hF0);
    send_item(mps_pkg::OP_TICK, 3'd6, 8'h33);
    send_item(mps_pkg::OP_TICK, 3'd1, 8'hCC);

    // Random part, one phase per period setting. The first 150 items of the
    // long phase run with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        write_period(PHASE_PERIOD[p]);
      end
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        calm <= (p == 1) && (n < 150);
        send_random(PHASE_TICK_PCT[p]);
      end
    end

    // Drain: lower valid in the step of the last transfer, wait for every
    // expected result, then wait out DRAIN_CYCLES to catch stray results.
    in_valid <= 1'b0;
    calm     <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("multichannel_pwm_shadowed_top: match");
    end else begin
      $display("multichannel_pwm_shadowed_top: mismatch");
    end
    $finish;
  end

endmodule
